// ----- design/ftqg_pkg.sv -----
// Shared types, register indexes and constants of the frame time quality governor.
// Used by the top level frame_time_quality_governor; depends on nothing.
`timescale 1ns / 1ps

package ftqg_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_RATE   = 3'd0;
    localparam logic [2:0] CFG_LEVEL_LOW    = 3'd1;
    localparam logic [2:0] CFG_LEVEL_MIN    = 3'd2;
    localparam logic [2:0] CFG_LEVEL_START  = 3'd3;
    localparam logic [2:0] CFG_BIG_SCREEN   = 3'd4;
    localparam logic [2:0] CFG_VIDEO_WIDTH  = 3'd5;
    localparam logic [2:0] CFG_VIDEO_HEIGHT = 3'd6;

    localparam int CFG_W = 14;

    // item kinds
    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    localparam logic [5:0] LEVEL_MAX  = 6'd63;
    localparam logic [5:0] FPS_MAX    = 6'd60;
    localparam int         MS_PER_SEC = 1000;

    // thresholds as exact integer ratios of the frame period
    localparam int PCT          = 100;
    localparam int SLOW_PCT     = 85;
    localparam int FAST_PCT     = 45;
    localparam int BIG_SLOW_AVG = 2;
    localparam int BIG_SLOW_SPD = 3;
    localparam int DEADLINE_PAD = 2;

    localparam logic [13:0] BIG_WIDTH  = 14'd1280;
    localparam logic [13:0] BIG_HEIGHT = 14'd720;

    typedef struct packed {
        logic        kind;
        logic [15:0] frame_time_ms;
        logic [31:0] now_ms;
        logic        draw_ready;
        logic        check_due;
    } in_item_t;

    typedef struct packed {
        logic        drawn;
        logic [15:0] average_ms;
        logic [5:0]  quality_level;
        logic        skip_pending;
        logic [31:0] skip_until_ms;
    } out_item_t;

    function automatic logic [5:0] raise_level(input logic [5:0] base);
        raise_level = (base >= LEVEL_MAX) ? LEVEL_MAX : base + 6'd1;
    endfunction

endpackage

// ----- design/frame_time_quality_governor.sv -----
// Sequence: from the accepting edge to out_valid, the bit-serial frame period divide
//   (1000/fps), a decision step, a read then a write per ring slot written (0 to 6
//   slots), an average step (reciprocal multiply) per average and the deadline and
//   quality step. Open items and undrawn big-screen frames write no ring slots and skip it.
// Flow: one item at a time; the next item is taken the cycle after the result is taken.
// Reset: asynchronous, active low; ring reads as zero, sum, position, level and skip clear,
//   configuration registers take their defaults. No clearing pass.
// Depends on ftqg_pkg and ftqg_div.
`timescale 1ns / 1ps

module frame_time_quality_governor #(
    parameter int WINDOW_LEN = 60
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_write,
    input  logic [2:0]                   cfg_index,
    input  logic [ftqg_pkg::CFG_W-1:0]   cfg_data,
    // item input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  ftqg_pkg::in_item_t           in_item,
    // result output
    output logic                         out_valid,
    input  logic                         out_stall,
    output ftqg_pkg::out_item_t          out_item
);

    import ftqg_pkg::*;

    // sum of the ring; all ring entries are 16 bits
    localparam int SUM_W = 16 + $clog2(WINDOW_LEN);
    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int CMP_W = 24;

    // average = sum / WINDOW_LEN as (sum * AVG_RCP) >> AVG_SHIFT, exact for every sum
    localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int RCP_W     = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // sequencer, one-hot
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_SPD    = 8'b00000010,   // wait for frame period from divider
        ST_DECIDE = 8'b00000100,   // open, or skip and draw gating
        ST_RD     = 8'b00001000,   // read ring slot
        ST_WR     = 8'b00010000,   // update sum, write ring slot
        ST_AVGS   = 8'b00100000,   // register average from the sum
        ST_CHECK  = 8'b01000000,   // deadline and quality step
        ST_OUT    = 8'b10000000    // hold result
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [7:0]  frame_rate_reg;
    logic [5:0]  level_low_reg;
    logic [5:0]  level_min_reg;
    logic [5:0]  level_start_reg;
    logic        big_screen_reg;
    logic [13:0] video_width_reg;
    logic [13:0] video_height_reg;

    // block state
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [31:0]           deadline_reg, deadline_next;
    logic                  armed_reg, armed_next;
    logic [5:0]            level_reg, level_next;
    logic [WINDOW_LEN-1:0] valid_reg, valid_next;
    logic [15:0]           fill_reg, fill_next;   // value of slots not written since open

    // per-item working registers
    in_item_t     item_reg, item_next;
    logic [9:0]   spd_reg, spd_next;
    logic [15:0]  avg_reg, avg_next;
    logic         drawn_reg, drawn_next;
    logic [15:0]  sample_reg, sample_next;
    logic [1:0]   slots_reg, slots_next;
    logic         final_reg, final_next;

    // ring memory
    logic [15:0] ring_mem [WINDOW_LEN];
    logic [15:0] rd_data_reg;
    logic        rd_valid_reg;
    logic        ring_we;

    // divider
    logic        div_start;
    logic [9:0]  div_num;
    logic [5:0]  div_den;
    logic        div_done;
    logic [9:0]  div_quo;

    logic [5:0]        fps;
    logic              accept_in;
    logic [15:0]       old_entry;
    logic              big_video;
    logic              skipped;
    logic              drawn_now;
    logic [16:0]       avg_pad;
    logic [16:0]       ft_delta;
    logic              slow;
    logic              fast;
    logic [9:0]        open_fill;
    logic [PROD_W-1:0] avg_prod;

    // clamp frame rate to 1..60
    always_comb
    begin
        if (frame_rate_reg == 8'd0)
            fps = 6'd1;
        else if (frame_rate_reg > {2'b00, FPS_MAX})
            fps = FPS_MAX;
        else
            fps = frame_rate_reg[5:0];
    end

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rate_reg   <= 8'd25;
            level_low_reg    <= 6'd4;
            level_min_reg    <= 6'd1;
            level_start_reg  <= 6'd2;
            big_screen_reg   <= 1'b0;
            video_width_reg  <= 14'd640;
            video_height_reg <= 14'd480;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_RATE:   frame_rate_reg   <= cfg_data[7:0];
                CFG_LEVEL_LOW:    level_low_reg    <= cfg_data[5:0];
                CFG_LEVEL_MIN:    level_min_reg    <= cfg_data[5:0];
                CFG_LEVEL_START:  level_start_reg  <= cfg_data[5:0];
                CFG_BIG_SCREEN:   big_screen_reg   <= cfg_data[0];
                CFG_VIDEO_WIDTH:  video_width_reg  <= cfg_data[13:0];
                CFG_VIDEO_HEIGHT: video_height_reg <= cfg_data[13:0];
                default:          ;
            endcase
        end
    end

    // Divider: frame period 1000/fps, started on accept.
    assign div_start = accept_in;
    assign div_num   = 10'(MS_PER_SEC);
    assign div_den   = fps;

    ftqg_div #(
        .NUM_W (10),
        .DEN_W (6)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // window average by reciprocal multiply
    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_RCP);

    // Ring slot value: a slot not written since open (or reset) holds the fill value.
    assign old_entry = rd_valid_reg ? rd_data_reg : fill_reg;

    assign big_video = (video_width_reg >= BIG_WIDTH) && (video_height_reg >= BIG_HEIGHT);
    assign skipped   = armed_reg && (item_reg.now_ms < deadline_reg);
    assign drawn_now = !skipped && item_reg.draw_ready;

    // deadline offsets: avg + 2 - spd in normal mode, ft - spd + 2 in big-screen mode
    assign avg_pad  = {1'b0, avg_reg} + 17'(DEADLINE_PAD);
    assign ft_delta = {1'b0, item_reg.frame_time_ms} - 17'(spd_reg) + 17'(DEADLINE_PAD);

    // threshold compares against the frame period, in exact integer ratios
    assign slow = big_screen_reg
        ? (CMP_W'(avg_reg) * CMP_W'(BIG_SLOW_AVG) > CMP_W'(spd_reg) * CMP_W'(BIG_SLOW_SPD))
        : (CMP_W'(avg_reg) * CMP_W'(PCT) > CMP_W'(spd_reg) * CMP_W'(SLOW_PCT));
    assign fast = CMP_W'(avg_reg) * CMP_W'(PCT) < CMP_W'(spd_reg) * CMP_W'(FAST_PCT);

    // 500/fps equals half the period rounded down
    assign open_fill = spd_reg >> 1;

    assign ring_we = (state_reg == ST_WR);

    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        pos_next      = pos_reg;
        deadline_next = deadline_reg;
        armed_next    = armed_reg;
        level_next    = level_reg;
        valid_next    = valid_reg;
        fill_next     = fill_reg;
        item_next     = item_reg;
        spd_next      = spd_reg;
        avg_next      = avg_reg;
        drawn_next    = drawn_reg;
        sample_next   = sample_reg;
        slots_next    = slots_reg;
        final_next    = final_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    item_next  = in_item;
                    state_next = ST_SPD;
                end
            end

            ST_SPD:
            begin
                if (div_done)
                begin
                    spd_next   = div_quo;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                drawn_next = 1'b0;
                final_next = 1'b1;
                state_next = ST_AVGS;
                if (item_reg.kind == KIND_OPEN)
                begin
                    // refill the whole ring at once through the fill value
                    fill_next  = {6'd0, open_fill};
                    valid_next = '0;
                    sum_next   = SUM_W'(open_fill) * SUM_W'(WINDOW_LEN);
                    pos_next   = '0;
                    level_next = level_start_reg;
                end
                else
                begin
                    if (big_screen_reg && big_video)
                        level_next = raise_level(level_low_reg);
                    if (armed_reg && !skipped)
                        armed_next = 1'b0;
                    drawn_next = drawn_now;
                    if (!big_screen_reg || drawn_now)
                    begin
                        // larger than the whole sum: three slots, else two
                        sample_next = item_reg.frame_time_ms;
                        slots_next  = (SUM_W'(item_reg.frame_time_ms) > sum_reg) ? 2'd3 : 2'd2;
                        final_next  = 1'b0;
                        state_next  = ST_RD;
                    end
                end
            end

            ST_RD:
            begin
                state_next = ST_WR;
            end

            ST_WR:
            begin
                sum_next            = sum_reg - SUM_W'(old_entry) + SUM_W'(sample_reg);
                valid_next[pos_reg] = 1'b1;
                pos_next   = (pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_reg + POS_W'(1);
                slots_next = slots_reg - 2'd1;
                state_next = (slots_reg == 2'd1) ? ST_AVGS : ST_RD;
            end

            ST_AVGS:
            begin
                avg_next   = avg_prod[AVG_SHIFT +: 16];
                state_next = final_reg ? ST_OUT : ST_CHECK;
            end

            ST_CHECK:
            begin
                // arm a new skip deadline when frames run late
                if (!big_screen_reg)
                begin
                    if (avg_pad >= {7'd0, spd_reg})
                    begin
                        deadline_next = item_reg.now_ms + 32'(avg_pad - 17'(spd_reg));
                        armed_next    = 1'b1;
                    end
                end
                else if (item_reg.frame_time_ms > 16'(spd_reg))
                begin
                    deadline_next = item_reg.now_ms + 32'(ft_delta);
                    armed_next    = 1'b1;
                end

                final_next = 1'b1;
                state_next = ST_OUT;
                if (drawn_reg && item_reg.check_due)
                begin
                    if (slow)
                    begin
                        if (level_reg <= level_low_reg)
                        begin
                            level_next  = raise_level(level_reg);
                            sample_next = 16'd0;
                            slots_next  = 2'd2;
                            state_next  = ST_RD;
                        end
                    end
                    else if ((level_reg > level_min_reg) && fast)
                    begin
                        level_next  = level_reg - 6'd1;
                        sample_next = 16'(spd_reg);
                        slots_next  = (SUM_W'(spd_reg) > sum_reg) ? 2'd3 : 2'd2;
                        state_next  = ST_RD;
                    end
                end
            end

            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            pos_reg      <= '0;
            deadline_reg <= '0;
            armed_reg    <= 1'b0;
            level_reg    <= '0;
            valid_reg    <= '0;
            fill_reg     <= '0;
            item_reg     <= '0;
            spd_reg      <= '0;
            avg_reg      <= '0;
            drawn_reg    <= 1'b0;
            sample_reg   <= '0;
            slots_reg    <= '0;
            final_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            pos_reg      <= pos_next;
            deadline_reg <= deadline_next;
            armed_reg    <= armed_next;
            level_reg    <= level_next;
            valid_reg    <= valid_next;
            fill_reg     <= fill_next;
            item_reg     <= item_next;
            spd_reg      <= spd_next;
            avg_reg      <= avg_next;
            drawn_reg    <= drawn_next;
            sample_reg   <= sample_next;
            slots_reg    <= slots_next;
            final_reg    <= final_next;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[pos_reg] <= sample_reg;
        rd_data_reg <= ring_mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= valid_reg[pos_reg];
    end

    // result
    always_comb
    begin
        out_item.drawn         = drawn_reg;
        out_item.average_ms    = avg_reg;
        out_item.quality_level = level_reg;
        out_item.skip_pending  = armed_reg;
        out_item.skip_until_ms = armed_reg ? deadline_reg : 32'd0;
    end

    // the block is free again right after a result is taken
    a_free_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !in_stall)
        else $error("block not ready after result taken");

    // an accepted item never yields a result in the next cycle
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (in_stall && !out_valid))
        else $error("result appeared without processing");

    // divider completes only while the sequencer waits for it
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_SPD))
        else $error("divider result not consumed");

    // a ring write burst always has slots left
    a_slots_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_WR) |-> (slots_reg != 2'd0))
        else $error("ring write with no slots left");

endmodule

// ----- design/ftqg_div.sv -----
// Restoring divider, one quotient bit per cycle, for the frame time quality governor.
// Self-contained; instantiated by frame_time_quality_governor.
`timescale 1ns / 1ps

module ftqg_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] quo_reg, quo_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract when it fits
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
